>>> rtl/rqh_pkg.sv
`default_nettype none

package rqh_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EST_W  = 20;
  localparam int unsigned PROD_W = TIME_W + EST_W;

  // command codes
  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // policy register values
  localparam logic FIFO = 1'b0;
  localparam logic HRRN = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED   = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_FULL       = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MULA,
    S_MULB,
    S_CMP,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] now_time;
    logic [EST_W-1:0]  burst_estimate;
  } in_word_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] chosen_id;
  } out_word_t;

  // one queue slot as kept in the ram
  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrival;
    logic [EST_W-1:0]  estimate;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/rqh_ram.sv
`default_nettype none

module rqh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ready_queue_hrrn_dispatch.sv
`default_nettype none

// ready queue with fifo or highest-response-ratio-next dispatch
//
// input channel: in_valid_i / in_stall_o / in_word_i carries one command word,
// either insert (append id, arrival = now_time, estimate) or dispatch
// output channel: out_valid_o / out_stall_i / out_word_o carries one status
// word per command, in command order
// cfg_we_i / cfg_wdata_i write the policy bit (fifo or hrrn), which the user must do
// only while idle; the block itself does not enforce it
// steps per command:
//   insert or empty dispatch: accept, then respond
//   fifo dispatch: read slot 0, then close up the queue
//   hrrn dispatch: each candidate is read, then takes two cross products on the one
//   shared 32x20 multiplier and a compare; then the compaction moves one entry a cycle
//   through the ram ports
// in_stall_o is high from acceptance until the result sits in the output
// register, so the next command is taken while a result waits downstream
// a stalled output word holds; the sequencer parks in its response state
// until the output register frees up
// reset empties the queue and selects fifo; ram contents are left as they are

module ready_queue_hrrn_dispatch #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rqh_pkg::in_word_t   in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rqh_pkg::out_word_t       out_word_o
);

  import rqh_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // control state
  state_e          state_q, state_d;
  logic            policy_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;       // scan index, then write pointer of the close-up
  logic            out_valid_q, out_valid_d;

  // payload
  logic [TIME_W-1:0] now_q, now_d;
  logic [CW-1:0]     best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_wait_q, best_wait_d;
  logic [EST_W-1:0]  best_est_q, best_est_d;
  logic [ID_W-1:0]   best_id_q, best_id_d;
  logic [TIME_W-1:0] cand_wait_q, cand_wait_d;
  logic [EST_W-1:0]  cand_est_q, cand_est_d;
  logic [ID_W-1:0]   cand_id_q, cand_id_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0] lhs_q, lhs_d;
  out_word_t         res_q, res_d;
  out_word_t         out_word_q, out_word_d;

  // ram side
  logic          ram_we;
  logic [CW-1:0] ram_wptr;
  entry_t        ram_wdata;
  logic [CW-1:0] rd_ptr;
  entry_t        ram_rdata;

  // shared unit operands
  logic [TIME_W-1:0] mul_a;
  logic [EST_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [TIME_W-1:0] rd_wait;
  logic              win;
  logic              out_load;
  logic [CW-1:0]     slot;

  rqh_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wptr[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // waiting time saturates at zero when now is before the arrival stamp
  assign rd_wait = (now_q >= ram_rdata.arrival) ? (now_q - ram_rdata.arrival) : '0;

  // first product is wait_c * est_b, second is wait_b * est_c
  assign mul_a = (state_q == S_MULB) ? best_wait_q : cand_wait_q;
  assign mul_b = (state_q == S_MULB) ? cand_est_q  : best_est_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // strict compare keeps the earliest entry on equal ratios
  assign win = lhs_q > prod_q;

  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    now_d       = now_q;
    best_idx_d  = best_idx_q;
    best_wait_d = best_wait_q;
    best_est_d  = best_est_q;
    best_id_d   = best_id_q;
    cand_wait_d = cand_wait_q;
    cand_est_d  = cand_est_q;
    cand_id_d   = cand_id_q;
    prod_d      = prod_q;
    lhs_d       = lhs_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_wptr    = count_q;
    ram_wdata   = ram_rdata;
    rd_ptr      = '0;
    slot        = best_idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          now_d = in_word_i.now_time;
          idx_d = '0;
          if (in_word_i.cmd == CMD_INSERT) begin
            if (count_q >= DEPTH_C) begin
              res_d = '{status: STAT_FULL, chosen_id: '0};
            end else begin
              ram_we            = 1'b1;
              ram_wptr          = count_q;
              ram_wdata.proc_id = in_word_i.proc_id;
              ram_wdata.arrival = in_word_i.now_time;
              // zero estimate is stored as one
              ram_wdata.estimate = (in_word_i.burst_estimate == '0) ?
                                   EST_W'(1) : in_word_i.burst_estimate;
              count_d = count_q + ONE_C;
              res_d   = '{status: STAT_INSERTED, chosen_id: '0};
            end
            state_d = S_RESP;
          end else if (count_q == '0) begin
            res_d   = '{status: STAT_EMPTY, chosen_id: '0};
            state_d = S_RESP;
          end else begin
            rd_ptr  = '0;
            state_d = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        if (idx_q == '0) begin
          // slot 0 seeds the running best
          best_idx_d  = '0;
          best_wait_d = rd_wait;
          best_est_d  = ram_rdata.estimate;
          best_id_d   = ram_rdata.proc_id;
          if (policy_q == FIFO || ONE_C >= count_q) begin
            slot    = '0;
            rd_ptr  = ONE_C;
            idx_d   = '0;
            state_d = S_SHIFT;
          end else begin
            rd_ptr  = ONE_C;
            idx_d   = ONE_C;
            state_d = S_LOAD;
          end
        end else begin
          cand_wait_d = rd_wait;
          cand_est_d  = ram_rdata.estimate;
          cand_id_d   = ram_rdata.proc_id;
          state_d     = S_MULA;
        end
      end

      S_MULA: begin
        prod_d  = mul_p;
        state_d = S_MULB;
      end

      S_MULB: begin
        lhs_d   = prod_q;
        prod_d  = mul_p;
        state_d = S_CMP;
      end

      S_CMP: begin
        if (win) begin
          best_idx_d  = idx_q;
          best_wait_d = cand_wait_q;
          best_est_d  = cand_est_q;
          best_id_d   = cand_id_q;
          slot        = idx_q;
        end
        if (idx_q + ONE_C < count_q) begin
          rd_ptr  = idx_q + ONE_C;
          idx_d   = idx_q + ONE_C;
          state_d = S_LOAD;
        end else begin
          rd_ptr  = slot + ONE_C;
          idx_d   = slot;
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // ram holds entry idx+1 here; move it down one slot
        if (idx_q + ONE_C < count_q) begin
          ram_we    = 1'b1;
          ram_wptr  = idx_q;
          ram_wdata = ram_rdata;
          rd_ptr    = idx_q + CW'(2);
          idx_d     = idx_q + ONE_C;
        end else begin
          count_d = count_q - ONE_C;
          res_d   = '{status: STAT_DISPATCHED, chosen_id: best_id_q};
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_word_d  = res_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= FIFO;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    best_idx_q  <= best_idx_d;
    best_wait_q <= best_wait_d;
    best_est_q  <= best_est_d;
    best_id_q   <= best_id_d;
    cand_wait_q <= cand_wait_d;
    cand_est_q  <= cand_est_d;
    cand_id_q   <= cand_id_d;
    prod_q      <= prod_d;
    lhs_q       <= lhs_d;
    res_q       <= res_d;
    out_word_q  <= out_word_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // queue occupancy stays within the ram
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("queue count beyond depth");

  // an insert that writes the ram only happens with room left
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_IDLE) |-> (count_q < DEPTH_C))
    else $error("insert written into a full queue");

  // running best always lies behind the candidate under test
  a_best_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULA) |-> (best_idx_q < idx_q && idx_q < count_q))
    else $error("best slot not behind the scan index");

  // finishing the close-up removes exactly one entry
  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && !(idx_q + ONE_C < count_q)) |=>
      (count_q == $past(count_q) - ONE_C && state_q == S_RESP))
    else $error("dispatch did not remove one entry");

  // only a dispatch carries an id
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != STAT_DISPATCHED) |->
      (out_word_o.chosen_id == '0))
    else $error("id on a non-dispatch word");

endmodule

`default_nettype wire

>>> tb/ready_queue_hrrn_dispatch_chk.sv
module ready_queue_hrrn_dispatch_chk #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  rqh_pkg::in_word_t  in_word_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  rqh_pkg::out_word_t out_word_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_cnt_o,
  output int unsigned dispatch_cnt_o,
  output int unsigned empty_cnt_o,
  output int unsigned full_cnt_o
);

  import rqh_pkg::*;

  // shadow copy of the ready queue
  logic              policy_q = FIFO;
  logic [ID_W-1:0]   slot_id  [QUEUE_DEPTH];
  logic [TIME_W-1:0] slot_arr [QUEUE_DEPTH];
  logic [EST_W-1:0]  slot_est [QUEUE_DEPTH];
  int unsigned       fill = 0;

  out_word_t   replies_q[$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_dispatched = 0;
  int unsigned n_empty = 0;
  int unsigned n_full = 0;

  assign fail_cnt_o     = n_fail;
  assign pending_o      = replies_q.size();
  assign checked_cnt_o  = n_checked;
  assign dispatch_cnt_o = n_dispatched;
  assign empty_cnt_o    = n_empty;
  assign full_cnt_o     = n_full;

  // wait saturates at zero when the entry arrived after now
  function automatic logic [TIME_W-1:0] waited(int unsigned s, logic [TIME_W-1:0] now);
    return (now >= slot_arr[s]) ? now - slot_arr[s] : '0;
  endfunction

  // applies one command to the shadow queue and returns the reply it causes
  function automatic out_word_t run_command(in_word_t w);
    out_word_t         r;
    int unsigned       pick;
    int unsigned       i;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    r.status    = STAT_INSERTED;
    r.chosen_id = '0;
    pick        = 0;
    if (w.cmd == CMD_INSERT) begin
      if (fill >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        slot_id[fill]  = w.proc_id;
        slot_arr[fill] = w.now_time;
        slot_est[fill] = (w.burst_estimate == '0) ? 20'd1 : w.burst_estimate;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      if (policy_q == HRRN) begin
        // exact ratio compare by cross products, strict so earliest wins ties
        for (i = 1; i < fill; i++) begin
          lhs = PROD_W'(waited(i, w.now_time));
          lhs = lhs * slot_est[pick];
          rhs = PROD_W'(waited(pick, w.now_time));
          rhs = rhs * slot_est[i];
          if (lhs > rhs) pick = i;
        end
      end
      r.status    = STAT_DISPATCHED;
      r.chosen_id = slot_id[pick];
      for (i = pick; i + 1 < fill; i++) begin
        slot_id[i]  = slot_id[i + 1];
        slot_arr[i] = slot_arr[i + 1];
        slot_est[i] = slot_est[i + 1];
      end
      fill--;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      policy_q = FIFO;
      fill     = 0;
      replies_q.delete();
    end else begin
      // reply side first, a word taken this edge cannot answer itself
      if (out_valid_i && !out_stall_i) begin
        if (replies_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected reply st=%0d id=%04h", $time,
                     out_word_i.status, out_word_i.chosen_id);
        end else begin
          exp_w = replies_q.pop_front();
          n_checked++;
          case (exp_w.status)
            STAT_DISPATCHED: n_dispatched++;
            STAT_EMPTY:      n_empty++;
            STAT_FULL:       n_full++;
            default: ;
          endcase
          if (out_word_i.status != exp_w.status ||
              out_word_i.chosen_id != exp_w.chosen_id) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: reply mismatch, expected st=%0d id=%04h, got st=%0d id=%04h",
                       $time, exp_w.status, exp_w.chosen_id,
                       out_word_i.status, out_word_i.chosen_id);
          end
        end
      end
      if (in_valid_i && !in_stall_i) replies_q.push_back(run_command(in_word_i));
      if (cfg_we_i) policy_q = cfg_wdata_i;
    end
  end

endmodule

>>> tb/ready_queue_hrrn_dispatch_tb.sv
module ready_queue_hrrn_dispatch_tb;
  import rqh_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PHASE_WORDS   = 200;
  localparam int unsigned RANDOM_PHASES = 6;
  // longest quiet stretch: well above a full hrrn scan plus the longest stall
  // or send gap, so this leaves ample margin
  localparam int unsigned STUCK_LIMIT   = 2000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int unsigned chk_fails, chk_pending, chk_checked, chk_dispatched, chk_empty, chk_full;
  int unsigned n_sent       = 0;
  int unsigned n_policy_set = 0;
  int unsigned stuck_cycles = 0;
  bit          steady_feed  = 1'b0;

  ready_queue_hrrn_dispatch #(
    .QUEUE_DEPTH (DEPTH)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  ready_queue_hrrn_dispatch_chk #(
    .QUEUE_DEPTH (DEPTH)
  ) i_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_word_i     (out_word),
    .fail_cnt_o     (chk_fails),
    .pending_o      (chk_pending),
    .checked_cnt_o  (chk_checked),
    .dispatch_cnt_o (chk_dispatched),
    .empty_cnt_o    (chk_empty),
    .full_cnt_o     (chk_full)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle length: half none, most short, a few long
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high between back-to-back words
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = steady_feed ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
  endtask

  // policy changes only once every reply is back and the block sits idle
  task automatic set_policy(input logic mode);
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_policy_set++;
  endtask

  // receiver: open stretches, sometimes long, broken up by stalls
  initial begin : receiver
    int unsigned hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (hold) @(negedge clk);
      hold = gap_len();
      if (hold > 0) out_stall <= 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no handshake for %0d cycles, %0d replies outstanding",
                 STUCK_LIMIT, chk_pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_word_t          w;
    int unsigned       k;
    int unsigned       p;
    int unsigned       insert_pct;
    int unsigned       roll;
    logic [TIME_W-1:0] clock_ms;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, starting in fifo mode
    set_policy(FIFO);

    // dispatch with nothing queued
    w                = '0;
    w.cmd            = CMD_DISPATCH;
    w.proc_id        = 16'hFFFF;
    w.burst_estimate = '1;
    send_word(w);

    // fill the queue to the brim with the field extremes mixed in
    for (k = 0; k < DEPTH; k++) begin
      w                = '0;
      w.cmd            = CMD_INSERT;
      w.proc_id        = ID_W'($urandom_range(1, 16'hFFFE));
      w.now_time       = 1000 * k;
      w.burst_estimate = EST_W'($urandom_range(2, 64));
      case (k)
        2: begin
          // zero estimate is taken as one
          w.proc_id        = '0;
          w.now_time       = '0;
          w.burst_estimate = '0;
        end
        3: begin
          // arrives at the end of time, so any later dispatch sees no wait
          w.proc_id        = '1;
          w.now_time       = '1;
          w.burst_estimate = '1;
        end
        4, 5: begin
          // identical wait and estimate, the earlier one must win
          w.now_time       = 32'd5000;
          w.burst_estimate = 20'd40;
        end
        6: w.burst_estimate = 20'd1;
        default: ;
      endcase
      send_word(w);
    end

    // one more insert is dropped as full
    w.cmd     = CMD_INSERT;
    w.proc_id = 16'hA5A5;
    send_word(w);

    // fifo hands out the two oldest
    w.cmd = CMD_DISPATCH;
    send_word(w);
    send_word(w);

    set_policy(HRRN);

    // at time zero every wait is zero, the ratios tie, the head wins
    w.now_time = '0;
    send_word(w);
    w.now_time = '1;
    send_word(w);
    w.now_time = 32'd20000;
    send_word(w);

    // random part: alternating policy, bursts biased toward filling or draining
    clock_ms = 32'd30000;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_policy((p % 2 == 0) ? FIFO : HRRN);
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (k % 40 == 0) begin
          roll        = $urandom_range(0, 2);
          insert_pct  = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
          steady_feed = ($urandom_range(0, 3) == 0);
        end
        w.cmd     = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DISPATCH;
        w.proc_id = ID_W'($urandom_range(0, 16'hFFFF));
        // mostly a rising clock, now and then a jump that may go backwards
        if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 40);
        w.now_time = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        roll = $urandom_range(0, 99);
        if (roll < 5) w.burst_estimate = '0;
        else if (roll < 10) w.burst_estimate = '1;
        else if (roll < 30) w.burst_estimate = EST_W'($urandom_range(1, 20'hFFFFF));
        else w.burst_estimate = EST_W'($urandom_range(1, 64));
        send_word(w);
      end
    end
    steady_feed = 1'b0;

    // drain, then give stray replies time to show up
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("sent %0d command words, checked %0d replies: %0d dispatched, %0d empty, %0d full",
             n_sent, chk_checked, chk_dispatched, chk_empty, chk_full);
    $display("policy written %0d times across fifo and hrrn, %0d failures",
             n_policy_set, chk_fails);
    if (chk_fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rqh_pkg.sv
rtl/rqh_ram.sv
rtl/ready_queue_hrrn_dispatch.sv
tb/ready_queue_hrrn_dispatch_chk.sv
tb/ready_queue_hrrn_dispatch_tb.sv
